@@ hdl/pcib_pkg.sv @@
// Shared widths, types and corner sign helpers for the plate corner box test.
package pcib_pkg;

    localparam int CORNERS    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LEN_W      = 31;
    localparam int TRIG_W     = 16;
    localparam int POS_W      = 32;
    localparam int PROD_W     = 48;  // trig x length, Q.31
    localparam int ROT_W      = 64;  // trig x trig x length, Q.45
    localparam int COORD_W    = 66;  // corner coordinate, Q.45 with headroom
    localparam int BOUND_W    = 34;  // box bound in Q18.16 after margin
    localparam int COUNT_W    = 4;
    localparam int Q16_TO_Q45 = 29;
    localparam int Q31_TO_Q45 = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X,
        CFG_MIN_Y,
        CFG_MIN_Z,
        CFG_LEN_X,
        CFG_LEN_Y,
        CFG_LEN_Z,
        CFG_MARGIN
    } cfg_idx_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t [CORNERS-1:0] x;
        coord_t [CORNERS-1:0] y;
        coord_t [CORNERS-1:0] z;
    } corners_t;

    // Corner i takes the negative half length on x for i mod 4 of one or two.
    function automatic logic x_neg(input logic [2:0] i);
        return (i[1:0] == 2'd1) || (i[1:0] == 2'd2);
    endfunction

    function automatic logic y_neg(input logic [2:0] i);
        return i[1];
    endfunction

    function automatic logic z_neg(input logic [2:0] i);
        return i[2];
    endfunction

endpackage

@@ hdl/pcib_xform.sv @@
// Four-stage pipeline that rotates and translates the eight plate corners.
module pcib_xform import pcib_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [LEN_W-1:0]          len_x,
    input  logic [LEN_W-1:0]          len_y,
    input  logic [LEN_W-1:0]          thick,
    input  logic signed [TRIG_W-1:0]  cos_y,
    input  logic signed [TRIG_W-1:0]  sin_y,
    input  logic signed [TRIG_W-1:0]  cos_z,
    input  logic signed [TRIG_W-1:0]  sin_z,
    input  logic signed [POS_W-1:0]   pos_x,
    input  logic signed [POS_W-1:0]   pos_y,
    input  logic signed [POS_W-1:0]   pos_z,
    output logic                      out_valid,
    input  logic                      out_ready,
    output corners_t                  corners
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] en;

    // stage 1: trig times half length
    logic signed [PROD_W-1:0] s1_cy_hx_reg, s1_cy_hx_next;
    logic signed [PROD_W-1:0] s1_sy_hz_reg, s1_sy_hz_next;
    logic signed [PROD_W-1:0] s1_sz_hy_reg, s1_sz_hy_next;
    logic signed [PROD_W-1:0] s1_cz_hy_reg, s1_cz_hy_next;
    logic signed [PROD_W-1:0] s1_cy_hz_reg, s1_cy_hz_next;
    logic signed [PROD_W-1:0] s1_sy_hx_reg, s1_sy_hx_next;
    logic signed [TRIG_W-1:0] s1_cz_reg, s1_sz_reg;
    logic signed [POS_W-1:0]  s1_px_reg, s1_py_reg, s1_pz_reg;

    // stage 2: second rotation of the tilted x/z terms
    logic signed [ROT_W-1:0]  s2_x1_reg, s2_x1_next;
    logic signed [ROT_W-1:0]  s2_x2_reg, s2_x2_next;
    logic signed [ROT_W-1:0]  s2_y1_reg, s2_y1_next;
    logic signed [ROT_W-1:0]  s2_y2_reg, s2_y2_next;
    logic signed [PROD_W-1:0] s2_sz_hy_reg, s2_cz_hy_reg, s2_cy_hz_reg, s2_sy_hx_reg;
    logic signed [POS_W-1:0]  s2_px_reg, s2_py_reg, s2_pz_reg;

    // stage 3: partial sums per sign combination
    coord_t s3_xa_reg [4];
    coord_t s3_xa_next [4];
    coord_t s3_ya_reg [4];
    coord_t s3_ya_next [4];
    coord_t s3_xb_reg [2];
    coord_t s3_xb_next [2];
    coord_t s3_yb_reg [2];
    coord_t s3_yb_next [2];
    coord_t s3_za_reg [2];
    coord_t s3_za_next [2];
    coord_t s3_zb_reg, s3_zb_next;

    // stage 4: finished corners
    corners_t corners_reg, corners_next;

    // a stage advances when empty or when the one after it advances
    always_comb begin
        en[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            vld_next[k] = en[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[STAGES-1];
    assign corners   = corners_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // The full-size bits read as Q15.17 are the half size.
    always_comb begin
        s1_cy_hx_next = cos_y * $signed({1'b0, len_x});
        s1_sy_hx_next = sin_y * $signed({1'b0, len_x});
        s1_sy_hz_next = sin_y * $signed({1'b0, thick});
        s1_cy_hz_next = cos_y * $signed({1'b0, thick});
        s1_sz_hy_next = sin_z * $signed({1'b0, len_y});
        s1_cz_hy_next = cos_z * $signed({1'b0, len_y});
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_cy_hx_reg <= s1_cy_hx_next;
            s1_sy_hx_reg <= s1_sy_hx_next;
            s1_sy_hz_reg <= s1_sy_hz_next;
            s1_cy_hz_reg <= s1_cy_hz_next;
            s1_sz_hy_reg <= s1_sz_hy_next;
            s1_cz_hy_reg <= s1_cz_hy_next;
            s1_cz_reg    <= cos_z;
            s1_sz_reg    <= sin_z;
            s1_px_reg    <= pos_x;
            s1_py_reg    <= pos_y;
            s1_pz_reg    <= pos_z;
        end
    end

    always_comb begin
        s2_x1_next = s1_cz_reg * s1_cy_hx_reg;
        s2_x2_next = s1_cz_reg * s1_sy_hz_reg;
        s2_y1_next = s1_sz_reg * s1_cy_hx_reg;
        s2_y2_next = s1_sz_reg * s1_sy_hz_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            s2_x1_reg    <= s2_x1_next;
            s2_x2_reg    <= s2_x2_next;
            s2_y1_reg    <= s2_y1_next;
            s2_y2_reg    <= s2_y2_next;
            s2_sz_hy_reg <= s1_sz_hy_reg;
            s2_cz_hy_reg <= s1_cz_hy_reg;
            s2_cy_hz_reg <= s1_cy_hz_reg;
            s2_sy_hx_reg <= s1_sy_hx_reg;
            s2_px_reg    <= s1_px_reg;
            s2_py_reg    <= s1_py_reg;
            s2_pz_reg    <= s1_pz_reg;
        end
    end

    // Index of the a-terms is {x negative, z negative}; of the b-terms, y negative.
    always_comb begin
        coord_t px_q, py_q, pz_q, sz_hy_q, cz_hy_q, cy_hz_q;
        px_q    = coord_t'($signed({s2_px_reg, {Q16_TO_Q45{1'b0}}}));
        py_q    = coord_t'($signed({s2_py_reg, {Q16_TO_Q45{1'b0}}}));
        pz_q    = coord_t'($signed({s2_pz_reg, {Q16_TO_Q45{1'b0}}}));
        sz_hy_q = coord_t'($signed({s2_sz_hy_reg, {Q31_TO_Q45{1'b0}}}));
        cz_hy_q = coord_t'($signed({s2_cz_hy_reg, {Q31_TO_Q45{1'b0}}}));
        cy_hz_q = coord_t'($signed({s2_cy_hz_reg, {Q31_TO_Q45{1'b0}}}));

        s3_xa_next[0] = coord_t'(s2_x1_reg) + coord_t'(s2_x2_reg);
        s3_xa_next[1] = coord_t'(s2_x1_reg) - coord_t'(s2_x2_reg);
        s3_xa_next[2] = coord_t'(s2_x2_reg) - coord_t'(s2_x1_reg);
        s3_xa_next[3] = -coord_t'(s2_x1_reg) - coord_t'(s2_x2_reg);
        s3_ya_next[0] = coord_t'(s2_y1_reg) + coord_t'(s2_y2_reg);
        s3_ya_next[1] = coord_t'(s2_y1_reg) - coord_t'(s2_y2_reg);
        s3_ya_next[2] = coord_t'(s2_y2_reg) - coord_t'(s2_y1_reg);
        s3_ya_next[3] = -coord_t'(s2_y1_reg) - coord_t'(s2_y2_reg);

        s3_xb_next[0] = px_q - sz_hy_q;
        s3_xb_next[1] = px_q + sz_hy_q;
        s3_yb_next[0] = py_q + cz_hy_q;
        s3_yb_next[1] = py_q - cz_hy_q;
        s3_za_next[0] = pz_q + cy_hz_q;
        s3_za_next[1] = pz_q - cy_hz_q;
        s3_zb_next    = coord_t'($signed({s2_sy_hx_reg, {Q31_TO_Q45{1'b0}}}));
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            s3_xa_reg <= s3_xa_next;
            s3_ya_reg <= s3_ya_next;
            s3_xb_reg <= s3_xb_next;
            s3_yb_reg <= s3_yb_next;
            s3_za_reg <= s3_za_next;
            s3_zb_reg <= s3_zb_next;
        end
    end

    always_comb begin
        logic [2:0] c;
        c = '0;
        corners_next = corners_reg;
        for (int i = 0; i < CORNERS; i++) begin
            c = 3'(i);
            corners_next.x[i] = s3_xa_reg[{x_neg(c), z_neg(c)}] + s3_xb_reg[y_neg(c)];
            corners_next.y[i] = s3_ya_reg[{x_neg(c), z_neg(c)}] + s3_yb_reg[y_neg(c)];
            corners_next.z[i] = x_neg(c) ? s3_za_reg[z_neg(c)] + s3_zb_reg
                                         : s3_za_reg[z_neg(c)] - s3_zb_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            corners_reg <= corners_next;
        end
    end

endmodule

@@ hdl/plate_corner_inside_box_mask.sv @@
// Top level: oriented plate corners tested against a configured box with margin.
//
// Input channel (s_*): one plate per word: full lengths, thickness, cos/sin of the
// tilt about y and the rotation about z, and the centre. Result channel (m_*): one
// word per plate: the mask of corners strictly inside the box, their count and an
// all-inside flag. Both channels use valid/ready.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (box minimum,
// box extent per axis, edge margin); indexes past the margin are dropped. Write
// only while no plate is in flight.
// Path: a word accepted on s_valid and s_ready loads the first of four transform
// stages, then moves through a compare stage and an output register before it
// shows on m_valid.
// Throughput: one plate per cycle unless m_ready stalls; each stage holds a word and a valid bit.
// A stalled receiver holds the output register; the stages fill behind it and
// s_ready falls once all six are full. No word is lost or repeated.
// Reset: clears the valid bits and all configuration registers to zero.
module plate_corner_inside_box_mask import pcib_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [LEN_W-1:0]          s_plate_len_x,
    input  logic [LEN_W-1:0]          s_plate_len_y,
    input  logic [LEN_W-1:0]          s_plate_thick,
    input  logic signed [TRIG_W-1:0]  s_cos_about_y,
    input  logic signed [TRIG_W-1:0]  s_sin_about_y,
    input  logic signed [TRIG_W-1:0]  s_cos_about_z,
    input  logic signed [TRIG_W-1:0]  s_sin_about_z,
    input  logic signed [POS_W-1:0]   s_center_x,
    input  logic signed [POS_W-1:0]   s_center_y,
    input  logic signed [POS_W-1:0]   s_center_z,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [CORNERS-1:0]        m_inside_mask,
    output logic [COUNT_W-1:0]        m_inside_count,
    output logic                      m_all_inside
);

    logic signed [POS_W-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic [LEN_W-1:0]        len_x_reg, len_y_reg, len_z_reg, margin_reg;

    coord_t lo_x_reg, lo_x_next, hi_x_reg, hi_x_next;
    coord_t lo_y_reg, lo_y_next, hi_y_reg, hi_y_next;
    coord_t lo_z_reg, lo_z_next, hi_z_reg, hi_z_next;

    logic     xf_valid, xf_ready;
    corners_t xf_corners;

    logic               cmp_vld_reg, cmp_vld_next, cmp_en;
    logic [CORNERS-1:0] cmp_mask_reg, cmp_mask_next;

    logic               out_vld_reg, out_vld_next, out_en;
    logic [CORNERS-1:0] out_mask_reg;
    logic [COUNT_W-1:0] out_count_reg, out_count_next;
    logic               out_all_reg, out_all_next;

    function automatic coord_t to_q45(input logic signed [BOUND_W-1:0] v);
        return coord_t'($signed({v, {Q16_TO_Q45{1'b0}}}));
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_x_reg  <= '0;
            min_y_reg  <= '0;
            min_z_reg  <= '0;
            len_x_reg  <= '0;
            len_y_reg  <= '0;
            len_z_reg  <= '0;
            margin_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_MIN_X:  min_x_reg  <= cfg_data;
                CFG_MIN_Y:  min_y_reg  <= cfg_data;
                CFG_MIN_Z:  min_z_reg  <= cfg_data;
                CFG_LEN_X:  len_x_reg  <= cfg_data[LEN_W-1:0];
                CFG_LEN_Y:  len_y_reg  <= cfg_data[LEN_W-1:0];
                CFG_LEN_Z:  len_z_reg  <= cfg_data[LEN_W-1:0];
                CFG_MARGIN: margin_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Bounds are registered from the configuration registers and settle well before a plate reaches the compare.
    always_comb begin
        logic signed [BOUND_W-1:0] mg;
        mg = $signed({1'b0, margin_reg});
        lo_x_next = to_q45(BOUND_W'(min_x_reg) + mg);
        lo_y_next = to_q45(BOUND_W'(min_y_reg) + mg);
        lo_z_next = to_q45(BOUND_W'(min_z_reg) + mg);
        hi_x_next = to_q45(BOUND_W'(min_x_reg) + $signed({1'b0, len_x_reg}) - mg);
        hi_y_next = to_q45(BOUND_W'(min_y_reg) + $signed({1'b0, len_y_reg}) - mg);
        hi_z_next = to_q45(BOUND_W'(min_z_reg) + $signed({1'b0, len_z_reg}) - mg);
    end

    always_ff @(posedge aclk) begin
        lo_x_reg <= lo_x_next;
        lo_y_reg <= lo_y_next;
        lo_z_reg <= lo_z_next;
        hi_x_reg <= hi_x_next;
        hi_y_reg <= hi_y_next;
        hi_z_reg <= hi_z_next;
    end

    pcib_xform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .len_x     (s_plate_len_x),
        .len_y     (s_plate_len_y),
        .thick     (s_plate_thick),
        .cos_y     (s_cos_about_y),
        .sin_y     (s_sin_about_y),
        .cos_z     (s_cos_about_z),
        .sin_z     (s_sin_about_z),
        .pos_x     (s_center_x),
        .pos_y     (s_center_y),
        .pos_z     (s_center_z),
        .out_valid (xf_valid),
        .out_ready (xf_ready),
        .corners   (xf_corners)
    );

    assign out_en       = !out_vld_reg || m_ready;
    assign cmp_en       = !cmp_vld_reg || out_en;
    assign xf_ready     = cmp_en;
    assign cmp_vld_next = cmp_en ? xf_valid : cmp_vld_reg;
    assign out_vld_next = out_en ? cmp_vld_reg : out_vld_reg;

    always_comb begin
        for (int i = 0; i < CORNERS; i++) begin
            cmp_mask_next[i] = (xf_corners.x[i] > lo_x_reg) && (xf_corners.x[i] < hi_x_reg)
                            && (xf_corners.y[i] > lo_y_reg) && (xf_corners.y[i] < hi_y_reg)
                            && (xf_corners.z[i] > lo_z_reg) && (xf_corners.z[i] < hi_z_reg);
        end
    end

    always_comb begin
        out_count_next = '0;
        for (int i = 0; i < CORNERS; i++) begin
            out_count_next = out_count_next + COUNT_W'(cmp_mask_reg[i]);
        end
        out_all_next = &cmp_mask_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            cmp_vld_reg <= cmp_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmp_en) begin
            cmp_mask_reg <= cmp_mask_next;
        end
        if (out_en) begin
            out_mask_reg  <= cmp_mask_reg;
            out_count_reg <= out_count_next;
            out_all_reg   <= out_all_next;
        end
    end

    assign m_valid        = out_vld_reg;
    assign m_inside_mask  = out_mask_reg;
    assign m_inside_count = out_count_reg;
    assign m_all_inside   = out_all_reg;

    // The input side only backs up when every stage is full behind a stalled output.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && cmp_vld_reg))
        else $error("input stalled while the pipeline has room");

    a_count_matches_mask: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_inside_count == COUNT_W'($countones(m_inside_mask))))
        else $error("inside count disagrees with mask");

    a_all_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_all_inside == (m_inside_count == COUNT_W'(CORNERS))))
        else $error("all-inside flag disagrees with count");

endmodule

@@ test/plate_box_tb_pkg.sv @@
// Plate and mask word types plus the corner-mask scoreboard for the plate box testbench.
package plate_box_tb_pkg;

    import pcib_pkg::*;

    localparam int Q16_UP      = 29;  // Q16.16 -> Q.45
    localparam int Q31_UP      = 14;  // Q.31 -> Q.45
    localparam int MAX_REPORTS = 10;

    typedef logic signed [71:0] wide_t;

    typedef struct packed {
        logic [LEN_W-1:0]  plate_len_x;
        logic [LEN_W-1:0]  plate_len_y;
        logic [LEN_W-1:0]  plate_thick;
        logic [TRIG_W-1:0] cos_about_y;
        logic [TRIG_W-1:0] sin_about_y;
        logic [TRIG_W-1:0] cos_about_z;
        logic [TRIG_W-1:0] sin_about_z;
        logic [POS_W-1:0]  center_x;
        logic [POS_W-1:0]  center_y;
        logic [POS_W-1:0]  center_z;
    } plate_t;

    typedef struct packed {
        logic [CORNERS-1:0] inside_mask;
        logic [COUNT_W-1:0] inside_count;
        logic               all_inside;
    } mask_word_t;

    class corner_mask_board;
        wide_t        box_lo[3];
        wide_t        box_len[3];
        wide_t        clearance;
        mask_word_t   expected_masks[$];
        int unsigned  errors;
        int unsigned  words_seen;

        function new();
            for (int k = 0; k < 3; k++) begin
                box_lo[k]  = '0;
                box_len[k] = '0;
            end
            clearance  = '0;
            errors     = 0;
            words_seen = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MIN_X:  box_lo[0]  = $signed(data);
                CFG_MIN_Y:  box_lo[1]  = $signed(data);
                CFG_MIN_Z:  box_lo[2]  = $signed(data);
                CFG_LEN_X:  box_len[0] = data[LEN_W-1:0];
                CFG_LEN_Y:  box_len[1] = data[LEN_W-1:0];
                CFG_LEN_Z:  box_len[2] = data[LEN_W-1:0];
                CFG_MARGIN: clearance  = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Strictly inside on one axis, with the same clearance from both faces.
        function bit clears_faces(wide_t v, int axis);
            wide_t lo_b;
            wide_t hi_b;
            lo_b = (box_lo[axis] + clearance) <<< Q16_UP;
            hi_b = (box_lo[axis] + box_len[axis] - clearance) <<< Q16_UP;
            return (v > lo_b) && (v < hi_b);
        endfunction

        function void note_plate(plate_t p);
            wide_t      hx, hy, hz, cy, sy, cz, sz, px, py, pz;
            wide_t      vx, vy, vz, a, b, x, y, z;
            mask_word_t want;
            // full length in Q16.16 is the half length in Q15.17
            hx = p.plate_len_x;
            hy = p.plate_len_y;
            hz = p.plate_thick;
            cy = $signed(p.cos_about_y);
            sy = $signed(p.sin_about_y);
            cz = $signed(p.cos_about_z);
            sz = $signed(p.sin_about_z);
            px = $signed(p.center_x);
            py = $signed(p.center_y);
            pz = $signed(p.center_z);
            px = px <<< Q16_UP;
            py = py <<< Q16_UP;
            pz = pz <<< Q16_UP;
            want = '0;
            for (int i = 0; i < CORNERS; i++) begin
                vx = ((i % 4) == 1 || (i % 4) == 2) ? -hx : hx;
                vy = ((i % 4) >= 2) ? -hy : hy;
                vz = (i >= 4) ? -hz : hz;
                a = cy * vx;
                b = sy * vz;
                x = cz * a - ((sz * vy) <<< Q31_UP) + cz * b + px;
                y = sz * a + ((cz * vy) <<< Q31_UP) + sz * b + py;
                z = ((cy * vz - sy * vx) <<< Q31_UP) + pz;
                if (clears_faces(x, 0) && clears_faces(y, 1) && clears_faces(z, 2)) begin
                    want.inside_mask[i] = 1'b1;
                    want.inside_count   = want.inside_count + 1'b1;
                end
            end
            want.all_inside = &want.inside_mask;
            expected_masks.insert(expected_masks.size(), want);
        endfunction

        function void check_mask(mask_word_t got);
            mask_word_t want;
            words_seen++;
            if (expected_masks.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("word %0d: nothing pending, got mask %02h count %0d all %0b",
                             words_seen, got.inside_mask, got.inside_count, got.all_inside);
                errors++;
                return;
            end
            want = expected_masks.pop_front();
            if (got.inside_mask !== want.inside_mask || got.inside_count !== want.inside_count
                    || got.all_inside !== want.all_inside) begin
                if (errors < MAX_REPORTS)
                    $display("word %0d: exp mask %02h count %0d all %0b, got %02h %0d %0b",
                             words_seen, want.inside_mask, want.inside_count, want.all_inside,
                             got.inside_mask, got.inside_count, got.all_inside);
                errors++;
            end
        endfunction

        function int pending();
            return expected_masks.size();
        endfunction

        function bit passed();
            return (errors == 0) && (expected_masks.size() == 0);
        endfunction
    endclass

endpackage

@@ test/plate_corner_inside_box_mask_tb.sv @@
// Testbench top: drives plates and box settings into the corner box test and scores the masks.
module plate_corner_inside_box_mask_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcib_pkg::*;
    import plate_box_tb_pkg::*;

    localparam int  CLK_HALF   = 2;
    localparam int  TIMEOUT_NS = 2_000_000;
    localparam int  SETTLE     = 10;
    localparam int  END_SETTLE = 20;
    localparam int  ONE        = 65536;   // 1.0 in Q16.16
    localparam int  UNIT       = 16384;   // 1.0 in Q2.14
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = '1;
    localparam logic [TRIG_W-1:0]    TRIG_MOST_NEG  = 16'h8000;
    localparam logic [TRIG_W-1:0]    TRIG_MOST_POS  = 16'h7fff;
    localparam logic [LEN_W-1:0]     LEN_MAX        = '1;
    localparam logic [POS_W-1:0]     POS_MAX        = 32'h7fff_ffff;
    localparam logic [POS_W-1:0]     POS_MIN        = 32'h8000_0000;
    localparam real                  PI             = 3.14159265358979;

    typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_SLOW} sink_mode_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    plate_t                 s_word    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    logic [CORNERS-1:0]     m_inside_mask;
    logic [COUNT_W-1:0]     m_inside_count;
    logic                   m_all_inside;

    corner_mask_board board;
    mask_word_t       seen_word;
    int               burst_left = 0;
    int               stall_left = 0;
    int               mode_left  = 0;
    sink_mode_t       sink_mode  = SINK_OPEN;
    longint           shape_lo[3];
    longint           shape_len[3];

    plate_corner_inside_box_mask i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_plate_len_x  (s_word.plate_len_x),
        .s_plate_len_y  (s_word.plate_len_y),
        .s_plate_thick  (s_word.plate_thick),
        .s_cos_about_y  (s_word.cos_about_y),
        .s_sin_about_y  (s_word.sin_about_y),
        .s_cos_about_z  (s_word.cos_about_z),
        .s_sin_about_z  (s_word.sin_about_z),
        .s_center_x     (s_word.center_x),
        .s_center_y     (s_word.center_y),
        .s_center_z     (s_word.center_z),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_inside_mask  (m_inside_mask),
        .m_inside_count (m_inside_count),
        .m_all_inside   (m_all_inside)
    );

    always #CLK_HALF aclk = ~aclk;

    initial begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: switch between open, choppy and slow stretches.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            sink_mode = sink_mode_t'($urandom_range(0, 2));
            mode_left = $urandom_range(100, 400);
        end else begin
            mode_left--;
        end
        if (stall_left != 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            case (sink_mode)
                SINK_CHOPPY: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
                SINK_SLOW:   if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(5, 20);
                default: ;
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_plate(s_word);
            if (m_valid && m_ready) begin
                seen_word.inside_mask  = m_inside_mask;
                seen_word.inside_count = m_inside_count;
                seen_word.all_inside   = m_all_inside;
                board.check_mask(seen_word);
            end
        end
    end

    function automatic logic [TRIG_W-1:0] to_q14(real v);
        return TRIG_W'($rtoi(v * 16384.0 + ((v < 0.0) ? -0.5 : 0.5)));
    endfunction

    function automatic void pick_angle(output logic [TRIG_W-1:0] c_q,
                                       output logic [TRIG_W-1:0] s_q);
        real rad;
        int  pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            // off the unit circle: any bit pattern
            c_q = TRIG_W'($urandom);
            s_q = TRIG_W'($urandom);
        end else begin
            if (pick < 4)
                rad = $urandom_range(0, 3) * 90.0;
            else
                rad = $urandom_range(0, 359);
            rad = rad * PI / 180.0;
            c_q = to_q14($cos(rad));
            s_q = to_q14($sin(rad));
        end
    endfunction

    function automatic plate_t plate_of(logic [LEN_W-1:0] lx, logic [LEN_W-1:0] ly,
                                        logic [LEN_W-1:0] th,
                                        logic [TRIG_W-1:0] cy, logic [TRIG_W-1:0] sy,
                                        logic [TRIG_W-1:0] cz, logic [TRIG_W-1:0] sz,
                                        logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                        logic [POS_W-1:0] pz);
        plate_t p;
        p.plate_len_x = lx;
        p.plate_len_y = ly;
        p.plate_thick = th;
        p.cos_about_y = cy;
        p.sin_about_y = sy;
        p.cos_about_z = cz;
        p.sin_about_z = sz;
        p.center_x    = px;
        p.center_y    = py;
        p.center_z    = pz;
        return p;
    endfunction

    // Plate sized and placed around the current box so that corners straddle the faces.
    function automatic plate_t shaped_plate();
        plate_t            p;
        longint            reach;
        longint            extent[3];
        longint            ctr[3];
        logic [TRIG_W-1:0] c1, s1, c2, s2;
        bit                on_grid;
        int                pick;
        on_grid = $urandom_range(0, 1);
        for (int k = 0; k < 3; k++) begin
            reach = (shape_len[k] > 0) ? shape_len[k] : ONE;
            extent[k] = longint'($urandom_range(0, 32'(reach))) >> $urandom_range(0, 3);
            ctr[k] = shape_lo[k] + longint'($urandom_range(0, 32'(reach)));
            pick = $urandom_range(0, 7);
            if (pick == 0)
                ctr[k] = ctr[k] - reach;
            else if (pick == 1)
                ctr[k] = ctr[k] + reach;
            if (on_grid) begin
                extent[k] = extent[k] & ~longint'(ONE - 1);
                ctr[k]    = ctr[k] & ~longint'(ONE - 1);
            end
        end
        pick_angle(c1, s1);
        pick_angle(c2, s2);
        p = plate_of(31'(extent[0]), 31'(extent[1]), 31'(extent[2]), c1, s1, c2, s2,
                     32'(ctr[0]), 32'(ctr[1]), 32'(ctr[2]));
        return p;
    endfunction

    function automatic plate_t noise_plate();
        return plate_of($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom);
    endfunction

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        board.write_reg(idx, data);
    endtask

    // Length and margin words carry a spare top bit; the block must drop it.
    task automatic write_box(input logic [31:0] lo_x, input logic [31:0] lo_y,
                             input logic [31:0] lo_z, input logic [31:0] len_x,
                             input logic [31:0] len_y, input logic [31:0] len_z,
                             input logic [31:0] margin);
        put_reg(CFG_MIN_X, lo_x);
        put_reg(CFG_MIN_Y, lo_y);
        put_reg(CFG_UNUSED_IDX, $urandom);
        put_reg(CFG_MIN_Z, lo_z);
        put_reg(CFG_LEN_X, len_x);
        put_reg(CFG_LEN_Y, len_y);
        put_reg(CFG_LEN_Z, len_z);
        put_reg(CFG_MARGIN, margin);
        cfg_wr_en <= 1'b0;
        shape_lo[0]  = $signed(lo_x);
        shape_lo[1]  = $signed(lo_y);
        shape_lo[2]  = $signed(lo_z);
        shape_len[0] = len_x[LEN_W-1:0];
        shape_len[1] = len_y[LEN_W-1:0];
        shape_len[2] = len_z[LEN_W-1:0];
    endtask

    task automatic send_plate(input plate_t p);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_word  <= p;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    // Drop valid, wait out every pending mask, then let the pipe settle.
    task automatic drain(input int settle);
        s_valid <= 1'b0;
        burst_left = 0;
        // let the monitor note the last accepted word first
        @(posedge aclk);
        while (board.pending() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic run_random(input int count, input int noise_pct);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_plate(noise_plate());
            else
                send_plate(shaped_plate());
        end
    endtask

    initial begin
        board = new();
        for (int k = 0; k < 3; k++) begin
            shape_lo[k]  = 0;
            shape_len[k] = 0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // box is empty out of reset
        send_plate(plate_of(0, 0, 0, UNIT, 0, UNIT, 0, 0, 0, 0));
        drain(SETTLE);

        write_box(-64 * ONE, -64 * ONE, -64 * ONE, 128 * ONE, 128 * ONE, 128 * ONE, 0);
        send_plate(plate_of(0, 0, 0, UNIT, 0, UNIT, 0, 0, 0, 0));
        send_plate(plate_of(0, 0, 0, UNIT, 0, UNIT, 0, -64 * ONE, 0, 0));
        send_plate(plate_of(128 * ONE, 128 * ONE, 128 * ONE, UNIT, 0, UNIT, 0, 0, 0, 0));
        send_plate(plate_of(127 * ONE, 127 * ONE, 127 * ONE, UNIT, 0, UNIT, 0, 0, 0, 0));
        send_plate(plate_of(64 * ONE, 64 * ONE, 64 * ONE, UNIT, 0, UNIT, 0, 40 * ONE, 0, 0));
        send_plate(plate_of(64 * ONE, 64 * ONE, 64 * ONE, UNIT, 0, UNIT, 0, 0, 40 * ONE, 0));
        send_plate(plate_of(64 * ONE, 64 * ONE, 64 * ONE, UNIT, 0, UNIT, 0, 0, 0, -40 * ONE));
        send_plate(plate_of(140 * ONE, 20 * ONE, 20 * ONE, UNIT, 0, 0, UNIT, 0, 0, 0));
        send_plate(plate_of(100 * ONE, 20 * ONE, 20 * ONE, 11585, 11585, UNIT, 0, 0, 0, 0));
        send_plate(plate_of(60 * ONE, 30 * ONE, 10 * ONE, -UNIT, -UNIT, -UNIT, -UNIT,
                            5 * ONE, -5 * ONE, 3 * ONE));
        send_plate(plate_of(10 * ONE, 10 * ONE, 10 * ONE, TRIG_MOST_NEG, TRIG_MOST_POS,
                            TRIG_MOST_POS, TRIG_MOST_NEG, 0, 0, 0));
        send_plate(plate_of(LEN_MAX, LEN_MAX, LEN_MAX, UNIT, 0, UNIT, 0, 0, 0, 0));
        send_plate(plate_of(LEN_MAX, LEN_MAX, LEN_MAX, TRIG_MOST_NEG, TRIG_MOST_NEG,
                            TRIG_MOST_NEG, TRIG_MOST_NEG, POS_MAX, POS_MAX, POS_MAX));
        send_plate(plate_of(0, 0, 0, UNIT, 0, UNIT, 0, POS_MAX, POS_MAX, POS_MAX));
        send_plate(plate_of(0, 0, 0, UNIT, 0, UNIT, 0, POS_MIN, POS_MIN, POS_MIN));
        send_plate(plate_of(LEN_MAX, LEN_MAX, LEN_MAX, TRIG_MOST_POS, TRIG_MOST_POS,
                            TRIG_MOST_POS, TRIG_MOST_POS, POS_MIN, POS_MIN, POS_MIN));
        drain(SETTLE);

        // margin leaves a quarter unit either side of the centre
        write_box(-64 * ONE, -64 * ONE, -64 * ONE, 128 * ONE, 128 * ONE, 128 * ONE,
                  63 * ONE + 3 * ONE / 4);
        send_plate(plate_of(0, 0, 0, UNIT, 0, UNIT, 0, 0, 0, 0));
        send_plate(plate_of(0, 0, 0, UNIT, 0, UNIT, 0, ONE / 4, 0, 0));
        drain(SETTLE);

        // twice the margin equals the extent: nothing can pass
        write_box(-64 * ONE, -64 * ONE, -64 * ONE, 128 * ONE, 128 * ONE, 128 * ONE, 64 * ONE);
        send_plate(plate_of(0, 0, 0, UNIT, 0, UNIT, 0, 0, 0, 0));
        drain(SETTLE);

        write_box($urandom_range(0, 2000 * ONE) - 1000 * ONE,
                  $urandom_range(0, 2000 * ONE) - 1000 * ONE,
                  $urandom_range(0, 2000 * ONE) - 1000 * ONE,
                  $urandom_range(50 * ONE, 2000 * ONE), $urandom_range(50 * ONE, 2000 * ONE),
                  $urandom_range(50 * ONE, 2000 * ONE), $urandom_range(0, 6 * ONE));
        run_random(275, 10);
        drain(SETTLE);

        write_box(POS_MIN, POS_MIN, POS_MIN, LEN_MAX, LEN_MAX, LEN_MAX, 0);
        run_random(250, 15);
        drain(SETTLE);

        write_box(POS_MAX, POS_MAX, POS_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
        run_random(100, 30);
        drain(SETTLE);

        write_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        run_random(100, 30);
        drain(SETTLE);

        // whole-unit box so axis-aligned corners can land on a face
        write_box(ONE * ($urandom_range(0, 40) - 20), ONE * ($urandom_range(0, 40) - 20),
                  ONE * ($urandom_range(0, 40) - 20), ONE * $urandom_range(4, 60),
                  ONE * $urandom_range(4, 60), ONE * $urandom_range(4, 60),
                  ONE * $urandom_range(0, 3));
        run_random(375, 10);
        drain(END_SETTLE);

        if (board.passed())
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
